// ===== rtl/pcdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcdd_pkg
// Shared types and constants of the pointer click and drag detector.
// ----------------------------------------------------------------------------
package pcdd_pkg;

    localparam int NUM_BUTTONS_DEF = 3;
    localparam int COORD_BITS_DEF  = 16;

    localparam logic [31:0] THRESH_RESET = 32'd4;

    typedef enum logic [1:0] {
        OP_DOWN = 2'd0,
        OP_UP   = 2'd1,
        OP_MOVE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        EV_CLICK      = 2'd0,
        EV_DRAG_START = 2'd1,
        EV_DRAG       = 2'd2,
        EV_DRAG_STOP  = 2'd3
    } t_ev;

    typedef struct packed {
        t_op        op;
        logic [1:0] button;
        logic [3:0] modifiers;
    } t_in_ctl;

    typedef struct packed {
        logic       stop;
        logic       click;
        logic       drag;
        logic [1:0] button;
        logic [3:0] modifiers;
    } t_pend_ctl;

endpackage : pcdd_pkg
`default_nettype wire

// ===== rtl/pointer_click_drag_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pointer_click_drag_detector
// Turns button down, button up and move events into click and drag events.
// ----------------------------------------------------------------------------
// An event is taken into an input register in any cycle in which the input
// register is empty or its event moves on. The core evaluates it combinationally
// (one squared distance per button against the threshold) and hands its
// results to a pending stage, which sends them through a single output
// register at one result per transfer. An event has 0 to NUM_BUTTONS + 1
// results and holds the pending stage until the last moves to the output
// register; events without results go at one per cycle while the pending
// stage is empty. The threshold resets to 4 and is written through the
// configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module pointer_click_drag_detector
    import pcdd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [31:0]                  i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [1:0]                   i_button,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_pos_y,
    input  wire logic [3:0]                   i_modifiers,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_event_res,
    output logic [1:0]                        o_event_button,
    output logic signed [COORD_BITS-1:0]      o_event_x,
    output logic signed [COORD_BITS-1:0]      o_event_y,
    output logic [3:0]                        o_event_modifiers,
    output logic                              o_last
);

    t_in_ctl                      in_ctl;
    t_in_ctl                      reg_ctl;
    logic                         reg_vld;
    logic signed [COORD_BITS-1:0] reg_x;
    logic signed [COORD_BITS-1:0] reg_y;
    logic                         load;
    logic                         emit_ready;
    t_pend_ctl                    pend;
    logic [NUM_BUTTONS-1:0]       start;
    logic signed [COORD_BITS-1:0] px [NUM_BUTTONS];
    logic signed [COORD_BITS-1:0] py [NUM_BUTTONS];

    assign o_cfg_ready = 1'b1;

    assign in_ctl.op        = t_op'(i_operation);
    assign in_ctl.button    = i_button;
    assign in_ctl.modifiers = i_modifiers;

    pcdd_in_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_ctl     (in_ctl),
        .i_x       (i_pos_x),
        .i_y       (i_pos_y),
        .i_consume (load),
        .o_valid   (reg_vld),
        .o_ctl     (reg_ctl),
        .o_x       (reg_x),
        .o_y       (reg_y)
    );

    pcdd_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COORD_BITS  (COORD_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (reg_vld),
        .i_ctl        (reg_ctl),
        .i_x          (reg_x),
        .i_y          (reg_y),
        .i_emit_ready (emit_ready),
        .o_load       (load),
        .o_pend       (pend),
        .o_start      (start),
        .o_px         (px),
        .o_py         (py)
    );

    pcdd_emit #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COORD_BITS  (COORD_BITS)
    ) u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (load),
        .i_pend            (pend),
        .i_start           (start),
        .i_x               (reg_x),
        .i_y               (reg_y),
        .i_px              (px),
        .i_py              (py),
        .o_ready           (emit_ready),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_event_res       (o_event_res),
        .o_event_button    (o_event_button),
        .o_event_x         (o_event_x),
        .o_event_y         (o_event_y),
        .o_event_modifiers (o_event_modifiers),
        .o_last            (o_last)
    );

endmodule : pointer_click_drag_detector
`default_nettype wire

// ===== rtl/pcdd_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcdd_in_reg
// Input register: holds one pointer event until the core takes it.
// ----------------------------------------------------------------------------
module pcdd_in_reg
    import pcdd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire t_in_ctl                      i_ctl,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic                         i_consume,
    output logic                              o_valid,
    output t_in_ctl                           o_ctl,
    output logic signed [COORD_BITS-1:0]      o_x,
    output logic signed [COORD_BITS-1:0]      o_y
);

    logic                         r_vld;
    logic                         n_vld;
    t_in_ctl                      r_ctl;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic                         accept;

    assign o_stall = r_vld && !i_consume;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (i_consume) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl <= i_ctl;
            r_x   <= i_x;
            r_y   <= i_y;
        end
    end

    assign o_valid = r_vld;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule : pcdd_in_reg
`default_nettype wire

// ===== rtl/pcdd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcdd_core
// Button state, threshold register and evaluation of one pointer event.
// ----------------------------------------------------------------------------
module pcdd_core
    import pcdd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [31:0]                  i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire t_in_ctl                      i_ctl,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic                         i_emit_ready,
    output logic                              o_load,
    output t_pend_ctl                         o_pend,
    output logic [NUM_BUTTONS-1:0]            o_start,
    output logic signed [COORD_BITS-1:0]      o_px [NUM_BUTTONS],
    output logic signed [COORD_BITS-1:0]      o_py [NUM_BUTTONS]
);

    localparam int SQ_W  = 2 * COORD_BITS + 2;
    localparam int CMP_W = (SQ_W > 32) ? SQ_W : 32;

    logic [31:0]                  r_thresh;
    logic [NUM_BUTTONS-1:0]       r_pressed;
    logic [NUM_BUTTONS-1:0]       n_pressed;
    logic [NUM_BUTTONS-1:0]       r_dragging;
    logic [NUM_BUTTONS-1:0]       n_dragging;
    logic signed [COORD_BITS-1:0] r_px [NUM_BUTTONS];
    logic signed [COORD_BITS-1:0] r_py [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]       hit;
    logic [NUM_BUTTONS-1:0]       far;
    logic [NUM_BUTTONS-1:0]       start;
    logic [NUM_BUTTONS-1:0]       set_pos;
    logic                         load;

    assign load = i_in_valid && i_emit_ready;

    // squared distance from each press point
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        logic signed [COORD_BITS:0]     dx;
        logic signed [COORD_BITS:0]     dy;
        logic signed [2*COORD_BITS+1:0] sqx;
        logic signed [2*COORD_BITS+1:0] sqy;
        logic [SQ_W-1:0]                d2;

        assign hit[b] = (int'(i_ctl.button) == b);
        assign dx  = {i_x[COORD_BITS-1], i_x} - {r_px[b][COORD_BITS-1], r_px[b]};
        assign dy  = {i_y[COORD_BITS-1], i_y} - {r_py[b][COORD_BITS-1], r_py[b]};
        assign sqx = dx * dx;
        assign sqy = dy * dy;
        assign d2  = SQ_W'(unsigned'(sqx)) + SQ_W'(unsigned'(sqy));
        assign far[b] = CMP_W'(d2) > CMP_W'(r_thresh);
    end

    always_comb begin
        n_pressed  = r_pressed;
        n_dragging = r_dragging;
        start      = '0;
        set_pos    = '0;
        o_pend.stop      = 1'b0;
        o_pend.click     = 1'b0;
        o_pend.drag      = 1'b0;
        o_pend.button    = i_ctl.button;
        o_pend.modifiers = i_ctl.modifiers;
        case (i_ctl.op)
            OP_DOWN: begin
                set_pos   = hit & ~r_pressed;
                n_pressed = r_pressed | hit;
            end
            OP_UP: begin
                o_pend.stop  = |(hit & r_dragging);
                o_pend.click = |(hit & r_pressed);
                n_dragging   = r_dragging & ~hit;
                n_pressed    = r_pressed & ~hit;
            end
            OP_MOVE: begin
                start       = r_pressed & far;
                n_dragging  = r_dragging | start;
                n_pressed   = r_pressed & ~start;
                o_pend.drag = |n_dragging;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed  <= '0;
            r_dragging <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_px[b] <= '0;
                r_py[b] <= '0;
            end
        end else if (load) begin
            r_pressed  <= n_pressed;
            r_dragging <= n_dragging;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (set_pos[b]) begin
                    r_px[b] <= i_x;
                    r_py[b] <= i_y;
                end
            end
        end
    end

    assign o_load  = load;
    assign o_start = start;
    assign o_px    = r_px;
    assign o_py    = r_py;

endmodule : pcdd_core
`default_nettype wire

// ===== rtl/pcdd_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcdd_emit
// Holds the pending results of one event and sends them one per transfer.
// ----------------------------------------------------------------------------
module pcdd_emit
    import pcdd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire t_pend_ctl                    i_pend,
    input  wire logic [NUM_BUTTONS-1:0]       i_start,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic signed [COORD_BITS-1:0] i_px [NUM_BUTTONS],
    input  wire logic signed [COORD_BITS-1:0] i_py [NUM_BUTTONS],
    output logic                              o_ready,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_event_res,
    output logic [1:0]                        o_event_button,
    output logic signed [COORD_BITS-1:0]      o_event_x,
    output logic signed [COORD_BITS-1:0]      o_event_y,
    output logic [3:0]                        o_event_modifiers,
    output logic                              o_last
);

    // pending set
    logic                         r_stop;
    logic                         r_click;
    logic                         r_drag;
    logic [NUM_BUTTONS-1:0]       r_start;
    logic [1:0]                   r_btn;
    logic [3:0]                   r_mods;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic signed [COORD_BITS-1:0] r_px [NUM_BUTTONS];
    logic signed [COORD_BITS-1:0] r_py [NUM_BUTTONS];

    // output register
    logic                         r_out_vld;
    logic                         n_out_vld;
    t_ev                          r_ev;
    t_ev                          n_ev;
    logic [1:0]                   r_ev_btn;
    logic [1:0]                   n_ev_btn;
    logic signed [COORD_BITS-1:0] r_ev_x;
    logic signed [COORD_BITS-1:0] n_ev_x;
    logic signed [COORD_BITS-1:0] r_ev_y;
    logic signed [COORD_BITS-1:0] n_ev_y;
    logic                         r_last;
    logic                         n_last;

    logic                         out_free;
    logic                         pick;
    logic                         found;
    logic                         rem_stop;
    logic                         rem_click;
    logic                         rem_drag;
    logic [NUM_BUTTONS-1:0]       rem_start;
    logic                         rem_any;

    always_comb begin
        out_free  = !r_out_vld || !i_stall;
        pick      = 1'b0;
        found     = 1'b0;
        rem_stop  = r_stop;
        rem_click = r_click;
        rem_drag  = r_drag;
        rem_start = r_start;
        n_ev      = r_ev;
        n_ev_btn  = r_ev_btn;
        n_ev_x    = r_ev_x;
        n_ev_y    = r_ev_y;
        if (out_free) begin
            if (r_stop) begin
                pick     = 1'b1;
                rem_stop = 1'b0;
                n_ev     = EV_DRAG_STOP;
                n_ev_btn = r_btn;
                n_ev_x   = r_x;
                n_ev_y   = r_y;
            end else if (r_click) begin
                pick      = 1'b1;
                rem_click = 1'b0;
                n_ev      = EV_CLICK;
                n_ev_btn  = r_btn;
                n_ev_x    = r_x;
                n_ev_y    = r_y;
            end else if (|r_start) begin
                pick = 1'b1;
                n_ev = EV_DRAG_START;
                // lowest button first
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (r_start[b] && !found) begin
                        found        = 1'b1;
                        rem_start[b] = 1'b0;
                        n_ev_btn     = 2'(b);
                        n_ev_x       = r_px[b];
                        n_ev_y       = r_py[b];
                    end
                end
            end else if (r_drag) begin
                pick     = 1'b1;
                rem_drag = 1'b0;
                n_ev     = EV_DRAG;
                n_ev_btn = '0;
                n_ev_x   = r_x;
                n_ev_y   = r_y;
            end
        end
        rem_any = rem_stop || rem_click || rem_drag || (|rem_start);
        n_last  = !rem_any;
        if (pick) begin
            n_out_vld = 1'b1;
        end else if (out_free) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_ready = !rem_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_stop    <= 1'b0;
            r_click   <= 1'b0;
            r_drag    <= 1'b0;
            r_start   <= '0;
        end else begin
            r_out_vld <= n_out_vld;
            if (i_load) begin
                r_stop  <= i_pend.stop;
                r_click <= i_pend.click;
                r_drag  <= i_pend.drag;
                r_start <= i_start;
            end else begin
                r_stop  <= rem_stop;
                r_click <= rem_click;
                r_drag  <= rem_drag;
                r_start <= rem_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_btn  <= i_pend.button;
            r_mods <= i_pend.modifiers;
            r_x    <= i_x;
            r_y    <= i_y;
            r_px   <= i_px;
            r_py   <= i_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pick) begin
            r_ev              <= n_ev;
            r_ev_btn          <= n_ev_btn;
            r_ev_x            <= n_ev_x;
            r_ev_y            <= n_ev_y;
            r_last            <= n_last;
            o_event_modifiers <= r_mods;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_event_res    = r_ev;
    assign o_event_button = r_ev_btn;
    assign o_event_x      = r_ev_x;
    assign o_event_y      = r_ev_y;
    assign o_last         = r_last;

endmodule : pcdd_emit
`default_nettype wire

// ===== sim/pointer_click_drag_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_click_drag_detector_tb
// Sends pointer events into the detector and checks each click and drag event
// against a cycle-free predictor of the per-button press and drag state. The
// drag threshold and the random idling of both channels change between phases.
// ----------------------------------------------------------------------------
module pointer_click_drag_detector_tb;
    import pcdd_pkg::*;

    localparam int          NB           = NUM_BUTTONS_DEF;
    localparam int          CW           = COORD_BITS_DEF;
    localparam int          CLK_PERIOD   = 4;
    localparam int          RESET_CYCLES = 9;
    localparam int          SETTLE_WAIT  = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [1:0]  OP_RESERVED  = 2'd3;
    localparam logic [1:0]  BTN_INVALID  = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [1:0]          button;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [3:0]          mods;
    } t_pointer_item;

    typedef struct packed {
        t_ev                 ev;
        logic [1:0]          button;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [3:0]          mods;
        logic                last;
    } t_pointer_event;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic [31:0]          cfg_data  = '0;
    logic                 cfg_ready;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_pointer_item        drv_item  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           res_ev;
    logic [1:0]           res_button;
    logic signed [CW-1:0] res_x;
    logic signed [CW-1:0] res_y;
    logic [3:0]           res_mods;
    logic                 res_last;

    t_pointer_item  pointer_items [$];
    t_pointer_event expected_events [$];

    logic [31:0]          drag_thresh = THRESH_RESET;
    bit                   btn_pressed [NB];
    bit                   btn_dragging [NB];
    logic signed [CW-1:0] press_x [NB] = '{default: '0};
    logic signed [CW-1:0] press_y [NB] = '{default: '0};

    logic signed [CW-1:0] cursor_x = '0;
    logic signed [CW-1:0] cursor_y = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    pointer_click_drag_detector DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (drv_item.op),
        .i_button         (drv_item.button),
        .i_pos_x          (drv_item.x),
        .i_pos_y          (drv_item.y),
        .i_modifiers      (drv_item.mods),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_event_res      (res_ev),
        .o_event_button   (res_button),
        .o_event_x        (res_x),
        .o_event_y        (res_y),
        .o_event_modifiers(res_mods),
        .o_last           (res_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic void track_pointer_event(input t_pointer_item it);
        t_pointer_event caused [$];
        t_pointer_event ev;
        longint dx;
        longint dy;
        longint dist_sq;
        longint limit_sq;
        bit any_dragging;
        any_dragging = 1'b0;
        limit_sq = {32'd0, drag_thresh};
        ev.button = '0;
        ev.x = it.x;
        ev.y = it.y;
        ev.mods = it.mods;
        ev.last = 1'b0;
        if (it.op == OP_DOWN) begin
            if (it.button < NB && !btn_pressed[it.button]) begin
                btn_pressed[it.button] = 1'b1;
                press_x[it.button] = it.x;
                press_y[it.button] = it.y;
            end
        end else if (it.op == OP_UP) begin
            if (it.button < NB) begin
                ev.button = it.button;
                if (btn_dragging[it.button]) begin
                    ev.ev = EV_DRAG_STOP;
                    caused.push_back(ev);
                    btn_dragging[it.button] = 1'b0;
                end
                if (btn_pressed[it.button]) begin
                    ev.ev = EV_CLICK;
                    caused.push_back(ev);
                    btn_pressed[it.button] = 1'b0;
                end
            end
        end else if (it.op == OP_MOVE) begin
            for (int b = 0; b < NB; b++) begin
                if (btn_pressed[b]) begin
                    dx = longint'(it.x) - longint'(press_x[b]);
                    dy = longint'(it.y) - longint'(press_y[b]);
                    dist_sq = dx * dx + dy * dy;
                    if (dist_sq > limit_sq) begin
                        btn_dragging[b] = 1'b1;
                        btn_pressed[b] = 1'b0;
                        ev.ev = EV_DRAG_START;
                        ev.button = 2'(b);
                        ev.x = press_x[b];
                        ev.y = press_y[b];
                        caused.push_back(ev);
                    end
                end
            end
            for (int b = 0; b < NB; b++) begin
                if (btn_dragging[b]) begin
                    any_dragging = 1'b1;
                end
            end
            if (any_dragging) begin
                ev.ev = EV_DRAG;
                ev.button = '0;
                ev.x = it.x;
                ev.y = it.y;
                caused.push_back(ev);
            end
        end
        if (caused.size() > 0) begin
            caused[caused.size() - 1].last = 1'b1;
        end
        foreach (caused[k]) begin
            expected_events.push_back(caused[k]);
        end
    endfunction

    // driver: one transfer per accepted item, holds the payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                track_pointer_event(drv_item);
            end
            if (!in_valid || !in_stall) begin
                if (pointer_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item <= pointer_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_events.size() == 0) begin
                    note_mismatch($sformatf("unexpected event %0d btn %0d (%0d,%0d) mods %h last %b",
                        res_ev, res_button, res_x, res_y, res_mods, res_last));
                end else begin
                    check_event(expected_events.pop_front());
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic check_event(input t_pointer_event exp_ev);
        if (res_ev !== exp_ev.ev || res_button !== exp_ev.button || res_x !== exp_ev.x
            || res_y !== exp_ev.y || res_mods !== exp_ev.mods || res_last !== exp_ev.last) begin
            note_mismatch($sformatf(
                "exp ev %0d btn %0d (%0d,%0d) mods %h last %b, got ev %0d btn %0d (%0d,%0d) mods %h last %b",
                exp_ev.ev, exp_ev.button, exp_ev.x, exp_ev.y, exp_ev.mods, exp_ev.last,
                res_ev, res_button, res_x, res_y, res_mods, res_last));
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [1:0] btn,
                              input int x, input int y, input logic [3:0] mods);
        t_pointer_item it;
        it.op = op;
        it.button = btn;
        it.x = CW'(x);
        it.y = CW'(y);
        it.mods = mods;
        pointer_items.push_back(it);
    endtask

    task automatic queue_random_items(input int count);
        t_pointer_item it;
        int unsigned sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            it.mods = 4'($urandom_range(15));
            it.button = 2'($urandom_range(NB - 1));
            if (sel < 30) begin
                it.op = OP_DOWN;
            end else if (sel < 55) begin
                it.op = OP_UP;
            end else if (sel < 95) begin
                it.op = OP_MOVE;
                it.button = 2'($urandom_range(3));
                if ($urandom_range(9) < 7) begin
                    cursor_x = cursor_x + CW'(int'($urandom_range(8)) - 4);
                    cursor_y = cursor_y + CW'(int'($urandom_range(8)) - 4);
                end else begin
                    cursor_x = CW'($urandom);
                    cursor_y = CW'($urandom);
                end
            end else begin
                // reserved operation or a button beyond the last one
                it.op = 2'($urandom_range(3));
                if (it.op != OP_RESERVED) begin
                    it.button = BTN_INVALID;
                end
            end
            it.x = cursor_x;
            it.y = cursor_y;
            pointer_items.push_back(it);
        end
    endtask

    task automatic wait_for_drain();
        while (pointer_items.size() > 0 || in_valid || expected_events.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        drag_thresh = value;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 46;

        // directed part at the reset threshold
        queue_item(OP_UP, 2'd0, 7, 7, 4'h1);
        queue_item(OP_MOVE, 2'd0, 9, 9, 4'h2);
        queue_item(OP_RESERVED, 2'd1, 3, 3, 4'h3);
        queue_item(OP_DOWN, BTN_INVALID, 1, 1, 4'h4);
        queue_item(OP_UP, BTN_INVALID, 1, 1, 4'h5);
        queue_item(OP_DOWN, 2'd0, 0, 0, 4'h6);
        queue_item(OP_DOWN, 2'd0, 100, 100, 4'h7);
        queue_item(OP_MOVE, 2'd3, 2, 0, 4'h8);
        queue_item(OP_MOVE, 2'd0, 2, 1, 4'h9);
        queue_item(OP_DOWN, 2'd0, 2, 1, 4'ha);
        queue_item(OP_UP, 2'd0, 3, 3, 4'hb);
        queue_item(OP_DOWN, 2'd1, 32767, 32767, 4'hc);
        queue_item(OP_DOWN, 2'd2, 0, 0, 4'hd);
        queue_item(OP_DOWN, 2'd0, -32768, -32768, 4'he);
        queue_item(OP_MOVE, 2'd0, 32767, -32768, 4'hf);
        queue_item(OP_MOVE, 2'd2, -1, -1, 4'h0);
        queue_item(OP_UP, 2'd1, -32768, 32767, 4'hf);
        queue_item(OP_UP, 2'd2, 32767, 0, 4'h5);
        queue_item(OP_UP, 2'd0, 0, -32768, 4'ha);
        queue_item(OP_MOVE, 2'd1, 4, 4, 4'h3);
        queue_item(OP_DOWN, 2'd2, 5, 5, 4'hf);
        queue_item(OP_UP, 2'd2, -5, -5, 4'h0);
        queue_item(OP_RESERVED, BTN_INVALID, -1, 32767, 4'hf);
        wait_for_drain();

        write_threshold(32'd0);
        queue_random_items(92);
        wait_for_drain();

        send_idle_pct = 46;
        recv_idle_pct = 23;
        write_threshold(32'hFFFF_FFFF);
        queue_random_items(92);
        wait_for_drain();

        write_threshold(32'($urandom_range(400)));
        queue_random_items(92);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(THRESH_RESET);
        queue_random_items(92);
        wait_for_drain();

        write_threshold($urandom);
        queue_random_items(92);
        wait_for_drain();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (expected_events.size() != 0) begin
            note_mismatch($sformatf("%0d expected events never arrived", expected_events.size()));
        end
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
